>>> hdl/ows_pkg.sv
package ows_pkg;

  // screen dimensions above this are treated as this
  localparam int MaxScreenDim = 4096;
  // width of the screen size registers
  localparam int DimW = 13;

  // item modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef enum logic [2:0] {
    REG_WINDOW_BASE     = 3'd0,
    REG_WINDOW_STRIDE   = 3'd1,
    REG_WINDOW_FORMAT   = 3'd2,
    REG_WINDOW_SIZE     = 3'd3,
    REG_WINDOW_POSITION = 3'd4,
    REG_SCREEN_WIDTH    = 3'd5,
    REG_SCREEN_HEIGHT   = 3'd6
  } cfg_reg_t;

  // everything the start item loads into the scan state
  typedef struct packed {
    logic            active;
    logic            wide;
    logic [DimW-1:0] vis_width;
    logic [DimW-1:0] rows;
    logic [47:0]     src_addr;
    logic [23:0]     dest_idx;
  } scan_start_t;

  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] d);
    return (d > DimW'(MaxScreenDim)) ? DimW'(MaxScreenDim) : d;
  endfunction

  // rgb565 fields move to the top of each byte, argb8888 drops alpha
  function automatic logic [23:0] expand_color(logic [31:0] raw, logic wide);
    logic [23:0] c;
    if (wide) begin
      c = raw[23:0];
    end else begin
      c = {raw[15:11], 3'b000, raw[10:5], 2'b00, raw[4:0], 3'b000};
    end
    return c;
  endfunction

endpackage

>>> hdl/overlay_window_scanout.sv
// Overlay window scanout. A start item (mode 0) clips the configured window
// against the screen and answers with the first source fetch address, or with
// more_pixels low when nothing is drawable. Each following pixel item (mode 1)
// carries one fetched source pixel and is answered with its screen index, its
// RGB888 color and the next fetch address; more_pixels drops with the last
// pixel. Items are accepted back to back, one per clock, while the result
// register is free or being drained. The start item's clipping, including a
// 16 x 32 bit multiply for skipped rows, is combinational; pixel items
// advance the addresses by adding the stride and screen width. The user must
// write registers through the config port only while no scan item is in
// flight; the block does not enforce it. Stride and screen width are read
// live on each row advance, everything else is taken at start.
module overlay_window_scanout import ows_pkg::*; (
  input  logic        clk,
  input  logic        rst,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [31:0] pixel_data,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        pixel_valid,
  output logic [23:0] dest_index,
  output logic [23:0] color,
  output logic        more_pixels,
  output logic [47:0] fetch_address
);

  logic [31:0]     window_base;
  logic [31:0]     window_stride;
  logic [7:0]      window_format;
  logic [31:0]     window_size;
  logic [31:0]     window_position;
  logic [DimW-1:0] screen_width;
  logic [DimW-1:0] screen_height;

  logic            scan_active;
  logic            wide;
  logic [DimW-1:0] visible_width;
  logic [DimW-1:0] rows_left;
  logic [DimW-1:0] column;
  logic [47:0]     row_source_address;
  logic [23:0]     row_dest_index;

  scan_start_t     start;
  logic            accept;
  logic [DimW-1:0] column_inc;
  logic            row_end;
  logic            last_row;
  logic            active_next;
  logic [47:0]     next_row_address;
  logic [47:0]     pixel_offset;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base     <= '0;
      window_stride   <= '0;
      window_format   <= '0;
      window_size     <= '0;
      window_position <= '0;
      screen_width    <= DimW'(320);
      screen_height   <= DimW'(240);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WINDOW_BASE:     window_base     <= cfg_data;
        REG_WINDOW_STRIDE:   window_stride   <= cfg_data;
        REG_WINDOW_FORMAT:   window_format   <= cfg_data[7:0];
        REG_WINDOW_SIZE:     window_size     <= cfg_data;
        REG_WINDOW_POSITION: window_position <= cfg_data;
        REG_SCREEN_WIDTH:    screen_width    <= cfg_data[DimW-1:0];
        REG_SCREEN_HEIGHT:   screen_height   <= cfg_data[DimW-1:0];
        default: ;
      endcase
    end
  end

  ows_clip u_clip (
    .window_base     (window_base),
    .window_stride   (window_stride),
    .window_format   (window_format),
    .window_size     (window_size),
    .window_position (window_position),
    .screen_width    (screen_width),
    .screen_height   (screen_height),
    .start           (start)
  );

  // pixel step
  assign column_inc       = column + DimW'(1);
  assign row_end          = column_inc >= visible_width;
  assign last_row         = rows_left == DimW'(1);
  assign active_next      = !(row_end && last_row);
  assign next_row_address = row_source_address + {16'b0, window_stride};
  assign pixel_offset     = wide ? 48'({column_inc, 2'b00}) : 48'({column_inc, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (mode == MODE_START) begin
          scan_active <= start.active;
        end else if (scan_active) begin
          scan_active <= active_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (mode == MODE_START) begin
        wide               <= start.wide;
        visible_width      <= start.vis_width;
        rows_left          <= start.rows;
        column             <= '0;
        row_source_address <= start.src_addr;
        row_dest_index     <= start.dest_idx;
        pixel_valid        <= 1'b0;
        dest_index         <= '0;
        color              <= '0;
        more_pixels        <= start.active;
        fetch_address      <= start.active ? start.src_addr : '0;
      end else if (scan_active) begin
        pixel_valid <= 1'b1;
        dest_index  <= row_dest_index + {11'b0, column};
        color       <= expand_color(pixel_data, wide);
        more_pixels <= active_next;
        if (row_end) begin
          column             <= '0;
          rows_left          <= rows_left - DimW'(1);
          row_source_address <= next_row_address;
          row_dest_index     <= row_dest_index + {11'b0, clamp_dim(screen_width)};
          fetch_address      <= active_next ? next_row_address : '0;
        end else begin
          column        <= column_inc;
          fetch_address <= row_source_address + pixel_offset;
        end
      end else begin
        pixel_valid   <= 1'b0;
        dest_index    <= '0;
        color         <= '0;
        more_pixels   <= 1'b0;
        fetch_address <= '0;
      end
    end
  end

endmodule

>>> hdl/ows_clip.sv
module ows_clip import ows_pkg::*; (
  input  logic [31:0]     window_base,
  input  logic [31:0]     window_stride,
  input  logic [7:0]      window_format,
  input  logic [31:0]     window_size,
  input  logic [31:0]     window_position,
  input  logic [DimW-1:0] screen_width,
  input  logic [DimW-1:0] screen_height,
  output scan_start_t     start
);

  logic [DimW-1:0]   sw;
  logic [DimW-1:0]   sh;
  logic              fmt_ok;
  logic              fmt_wide;
  logic [15:0]       w;
  logic [15:0]       h;
  logic [15:0]       x;
  logic [15:0]       margin;
  logic signed [19:0] y;
  logic signed [19:0] room;
  logic signed [19:0] hv;
  logic signed [19:0] first;
  logic              x_off;
  logic              y_off;
  logic [DimW-1:0]   room_x;
  logic [DimW-1:0]   wv;
  logic [DimW-1:0]   top;
  logic [47:0]       skip_bytes;
  logic [2*DimW-1:0] top_offset;

  assign sw     = clamp_dim(screen_width);
  assign sh     = clamp_dim(screen_height);
  assign w      = window_size[31:16];
  assign h      = window_size[15:0];
  assign x      = window_position[15:0];
  assign margin = window_position[31:16];

  always_comb begin
    fmt_ok   = 1'b0;
    fmt_wide = 1'b0;
    unique case (window_format) inside
      [8'd2:8'd5]: fmt_ok = 1'b1;
      8'd6, 8'd7: begin
        fmt_ok   = 1'b1;
        fmt_wide = 1'b1;
      end
      default: ;
    endcase
  end

  // top edge counted down from the bottom of the screen, may be negative
  assign y    = $signed({7'b0, sh}) - $signed({4'b0, h}) - $signed({4'b0, margin});
  assign room = $signed({7'b0, sh}) - y;
  assign hv   = ($signed({4'b0, h}) > room) ? room : $signed({4'b0, h});

  // rows above the screen are skipped
  assign first = y[19] ? -y : 20'sd0;
  assign top   = y[19] ? '0 : y[DimW-1:0];

  assign x_off  = x >= {3'b0, sw};
  assign y_off  = y >= $signed({7'b0, sh});
  assign room_x = sw - x[DimW-1:0];
  assign wv     = (w > {3'b0, room_x}) ? room_x : w[DimW-1:0];

  assign skip_bytes = first[15:0] * window_stride;
  assign top_offset = top * sw;

  always_comb begin
    start.active = (window_base != '0) && (w != '0) && (h != '0) && fmt_ok &&
                   (window_stride != '0) && !x_off && !y_off && (wv != '0) &&
                   (hv > 20'sd0) && (first < hv);
    start.wide      = fmt_wide;
    start.vis_width = wv;
    start.rows      = DimW'(hv - first);
    start.src_addr  = {16'b0, window_base} + skip_bytes;
    start.dest_idx  = 24'(top_offset + (2*DimW)'(x));
  end

endmodule
